/* sv/pzb_pkg.sv */
// Shared types, constants and functions of the POSTNET ZIP bar encoder.
// Used by every module of the block; depends on nothing else.
package pzb_pkg;

    localparam int ZIP_W          = 17;
    localparam int ZIP_DIGITS     = 5;
    localparam int DIGIT_W        = 4;
    localparam int BCD_W          = ZIP_DIGITS * DIGIT_W;
    localparam int BARS_PER_DIGIT = 5;
    localparam int BAR_CNT        = 32;
    localparam int BAR_CNT_W      = $clog2(BAR_CNT);
    localparam int STEP_CNT_W     = $clog2(ZIP_W);
    localparam int SUM_W          = 6;
    localparam int IN_TDATA_W     = ((ZIP_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W    = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [ZIP_W-1:0] ZIP_MOD = ZIP_W'(100000);

    typedef logic [BAR_CNT-1:0] t_bar_word;

    typedef struct packed {
        logic      valid;
        t_bar_word word;
    } t_q_entry;

    function automatic logic [BARS_PER_DIGIT-1:0] digit_bars(input logic [DIGIT_W-1:0] d);
        logic [BARS_PER_DIGIT-1:0] p;
        case (d)
            4'd0:    p = 5'b11000;
            4'd1:    p = 5'b00011;
            4'd2:    p = 5'b00101;
            4'd3:    p = 5'b00110;
            4'd4:    p = 5'b01001;
            4'd5:    p = 5'b01010;
            4'd6:    p = 5'b01100;
            4'd7:    p = 5'b10001;
            4'd8:    p = 5'b10010;
            4'd9:    p = 5'b10100;
            default: p = 5'b00000;
        endcase
        return p;
    endfunction

    // The digit sum is at most 45, so three compare-subtract steps reduce it.
    function automatic logic [DIGIT_W-1:0] check_digit(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] r;
        r = sum;
        if (r >= SUM_W'(40)) r = r - SUM_W'(40);
        if (r >= SUM_W'(20)) r = r - SUM_W'(20);
        if (r >= SUM_W'(10)) r = r - SUM_W'(10);
        if (r == '0) begin
            return '0;
        end
        return DIGIT_W'(SUM_W'(10) - r);
    endfunction

endpackage

/* sv/postnet_zip_bar_encoder_unit.sv */
// POSTNET encoder for five-digit ZIP codes: front end, bar-word queue, back end.
// Throughput: 32 bars per code, one bar per cycle while the output stream is ready;
// the output stream, not the front end, sets the rate of codes.
// Reset (synchronous, active low) empties the queue and drops any code in flight.
// Depends on pzb_pkg, pzb_front, pzb_queue and pzb_back.
module postnet_zip_bar_encoder_unit #(
    parameter int QUEUE_DEPTH = pzb_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [16:0] zip_code, [23:17] zero
    input  logic [pzb_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] bar_tall, [7:1] zero
    output logic [pzb_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);
    import pzb_pkg::*;

    t_q_entry push, head;
    logic     full, pop, bar;

    pzb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_zip   (i_s_axis_tdata[ZIP_W-1:0]),
        .o_push  (push),
        .i_full  (full)
    );

    pzb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head)
    );

    pzb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_bar   (bar),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, bar};

endmodule

/* sv/pzb_front.sv */
// Front end: takes a ZIP code request, converts it to decimal digits by
// shift-and-add-3 and builds the 32-bar word. Depends on pzb_pkg.
module pzb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [pzb_pkg::ZIP_W-1:0]   i_zip,
    output pzb_pkg::t_q_entry           o_push,
    input  logic                        i_full
);
    import pzb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_PUSH
    } t_state;

    t_state                r_state, n_state;
    logic [ZIP_W-1:0]      r_bin, n_bin;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [STEP_CNT_W-1:0] r_step, n_step;

    logic [BCD_W-1:0]      adj;
    logic [SUM_W-1:0]      sum;
    t_bar_word             word;

    always_comb begin
        for (int i = 0; i < ZIP_DIGITS; i++) begin
            adj[i*DIGIT_W +: DIGIT_W] = (r_bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) ?
                r_bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3) : r_bcd[i*DIGIT_W +: DIGIT_W];
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < ZIP_DIGITS; i++) begin
            sum = sum + SUM_W'(r_bcd[i*DIGIT_W +: DIGIT_W]);
        end
        word = '0;
        word[BAR_CNT-1] = 1'b1;
        word[0]         = 1'b1;
        for (int i = 0; i < ZIP_DIGITS; i++) begin
            word[BAR_CNT-1-BARS_PER_DIGIT*(ZIP_DIGITS-i) +: BARS_PER_DIGIT] =
                digit_bars(r_bcd[i*DIGIT_W +: DIGIT_W]);
        end
        word[1 +: BARS_PER_DIGIT] = digit_bars(check_digit(sum));
    end

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_bin   = (i_zip >= ZIP_MOD) ? i_zip - ZIP_MOD : i_zip;
                    n_bcd   = '0;
                    n_step  = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                {n_bcd, n_bin} = {adj, r_bin} << 1;
                n_step = r_step + 1'b1;
                if (r_step == STEP_CNT_W'(ZIP_W - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_step <= n_step;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_push.valid = (r_state == S_PUSH) && !i_full;
    assign o_push.word  = word;

endmodule

/* sv/pzb_queue.sv */
// Short queue of finished bar words between the front and back ends.
// Depends on pzb_pkg.
module pzb_queue #(
    parameter int DEPTH = pzb_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pzb_pkg::t_q_entry i_push,
    output logic              o_full,
    input  logic              i_pop,
    output pzb_pkg::t_q_entry o_head
);
    import pzb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bar_word         r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push.valid && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push.valid) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.word;
        end
    end

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_mem[r_rd_ptr];

endmodule

/* sv/pzb_back.sv */
// Back end: shifts a 32-bar word out one bar per request on the output
// stream and flags the closing frame bar. Depends on pzb_pkg.
module pzb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pzb_pkg::t_q_entry    i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_bar,
    output logic                 o_last
);
    import pzb_pkg::*;

    logic                 r_active;
    t_bar_word            r_bars;
    logic [BAR_CNT_W-1:0] r_cnt;
    logic                 take, at_end;

    assign take   = o_valid && i_ready;
    assign at_end = (r_cnt == BAR_CNT_W'(BAR_CNT - 1));
    assign o_pop  = i_head.valid && (!r_active || (take && at_end));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else if (take) begin
            r_cnt <= r_cnt + 1'b1;
            if (at_end) begin
                r_active <= 1'b0;
            end
        end
        if (o_pop) begin
            r_bars <= i_head.word;
        end else if (take) begin
            r_bars <= r_bars << 1;
        end
    end

    assign o_valid = r_active;
    assign o_bar   = r_bars[BAR_CNT-1];
    assign o_last  = at_end;

endmodule

/* sv/pzb_checker.sv */
// Port-level checker for the POSTNET encoder, bound to the top level.
// Depends on pzb_pkg and postnet_zip_bar_encoder_unit.
module pzb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [pzb_pkg::OUT_TDATA_W-1:0] i_m_axis_tdata,
    input logic                            i_m_axis_tlast
);
    import pzb_pkg::*;

    logic [BAR_CNT_W-1:0] r_bar_idx;
    logic                 take;

    assign take = i_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_idx <= '0;
        end else if (take) begin
            r_bar_idx <= r_bar_idx + 1'b1;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tlast))
        else $error("stalled bar changed");

    a_last_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> (i_m_axis_tlast == (r_bar_idx == BAR_CNT_W'(BAR_CNT - 1))))
        else $error("tlast not on the 32nd bar");

    a_frame_bars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && (r_bar_idx == '0 || r_bar_idx == BAR_CNT_W'(BAR_CNT - 1))
            |-> i_m_axis_tdata[0])
        else $error("frame bar not tall");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> (i_m_axis_tdata[OUT_TDATA_W-1:1] == '0))
        else $error("padding bits not zero");

endmodule

bind postnet_zip_bar_encoder_unit pzb_checker u_pzb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the POSTNET ZIP bar encoder: ZIP requests in, 32 bars out each.
// Predicts every bar from the decimal digits and check digit; depends on pzb_pkg and the RTL.
module tb_top;
    import pzb_pkg::*;

    localparam int RANDOM_CODES = 320;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic tall;
        logic last;
    } t_bar;

    class t_postnet_scoreboard;
        t_bar        pending_bars[$];
        int unsigned mismatches;
        int unsigned codes_noted;
        int unsigned bars_checked;

        function new();
            mismatches   = 0;
            codes_noted  = 0;
            bars_checked = 0;
        endfunction

        function logic [4:0] two_of_five(int unsigned digit);
            case (digit)
                0:       return 5'b11000;
                1:       return 5'b00011;
                2:       return 5'b00101;
                3:       return 5'b00110;
                4:       return 5'b01001;
                5:       return 5'b01010;
                6:       return 5'b01100;
                7:       return 5'b10001;
                8:       return 5'b10010;
                default: return 5'b10100;
            endcase
        endfunction

        // Codes above 99999 keep only their five low-order decimal digits.
        function void note_zip(logic [ZIP_W-1:0] zip);
            int unsigned value;
            int unsigned sum;
            int unsigned digits[6];
            logic [4:0]  pattern;
            value = zip % 100000;
            sum   = 0;
            for (int k = 4; k >= 0; k--) begin
                digits[k] = value % 10;
                value     = value / 10;
                sum       = sum + digits[k];
            end
            digits[5] = (10 - (sum % 10)) % 10;
            pending_bars.push_back('{tall: 1'b1, last: 1'b0});
            for (int d = 0; d < 6; d++) begin
                pattern = two_of_five(digits[d]);
                for (int b = 4; b >= 0; b--) begin
                    pending_bars.push_back('{tall: pattern[b], last: 1'b0});
                end
            end
            pending_bars.push_back('{tall: 1'b1, last: 1'b1});
            codes_noted++;
        endfunction

        function void check_bar(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
            t_bar expected;
            if (pending_bars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected bar: tdata=%h tlast=%0b", tdata, tlast);
                end
                return;
            end
            expected = pending_bars.pop_front();
            bars_checked++;
            if (tdata[0] !== expected.tall || tlast !== expected.last ||
                tdata[OUT_TDATA_W-1:1] !== '0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Bar mismatch: expected tall=%0b last=%0b, got tdata=%h tlast=%0b",
                             expected.tall, expected.last, tdata, tlast);
                end
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;

    logic                   hold_off = 1'b0;
    logic                   sender_calm = 1'b0;
    int unsigned            codes_sent = 0;
    int unsigned            cycle_count = 0;

    t_postnet_scoreboard sb = new();

    logic [ZIP_W-1:0] corner_zips[$] = '{
        17'd0, 17'd99999, 17'd1, 17'd10, 17'd123, 17'd12345, 17'd55000, 17'd19,
        17'd13579, 17'd24680, 17'd11111, 17'd99991, 17'd67890, 17'd100000,
        17'd131071, 17'd109999, 17'd65536, 17'd43210
    };

    postnet_zip_bar_encoder_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && s_tvalid && o_s_axis_tready) begin
            sb.note_zip(s_tdata[ZIP_W-1:0]);
        end
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            sb.check_bar(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    // Each request stays offered until the block accepts it.
    task automatic send_zip(input logic [ZIP_W-1:0] zip);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - ZIP_W){1'b0}}, zip};
        do @(posedge i_clk); while (!o_s_axis_tready);
        codes_sent++;
    endtask

    function automatic logic [ZIP_W-1:0] random_zip();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            return ZIP_W'($urandom_range(0, 99999));
        end else if (pick == 7) begin
            return ZIP_W'($urandom_range(100000, 131071));
        end else if (pick == 8) begin
            return ZIP_W'($urandom_range(0, 999));
        end
        return ZIP_W'($urandom);
    endfunction

    initial begin : bar_sink
        int stall;
        int unsigned bars_taken;
        logic calm;
        bars_taken = 0;
        calm = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (bars_taken % 64 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0 || hold_off) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            bars_taken++;
        end
    end

    initial begin : output_hold
        while (codes_sent < corner_zips.size() + 10) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (corner_zips[i]) begin
            send_zip(corner_zips[i]);
        end
        for (int n = 0; n < RANDOM_CODES; n++) begin
            if (n % 40 == 0) begin
                sender_calm = ($urandom_range(0, 3) == 0);
            end
            send_zip(random_zip());
        end
        s_tvalid <= 1'b0;
        while (sb.pending_bars.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Encoded %0d ZIP codes (directed corners, out-of-range and random values).",
                 sb.codes_noted);
        $display("Checked %0d bars under random stalls and one long output hold-off.",
                 sb.bars_checked);
        if (sb.mismatches == 0 && sb.pending_bars.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Mismatches: %0d", sb.mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
